// File: design/sfc_pkg.sv
// shared constants, substitution tables and helper functions for the audio word cipher
package sfc_pkg;

	localparam int ROUNDS = 32;
	localparam int KEY_BYTES = 8;
	localparam int KEY_W = 64;
	localparam int WORD_W = 16;
	localparam int BYTE_W = 8;
	localparam int POS_W = 3;
	localparam int ROUNDS_MOD3 = ROUNDS % 3;
	localparam int FINAL_IDX_ENC = ROUNDS % KEY_BYTES;
	localparam int FINAL_IDX_DEC = 0;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [KEY_BYTES-1:0] key_sel_t;

	typedef enum logic {
		ACT_ENCRYPT = 1'b0,
		ACT_DECRYPT = 1'b1
	} action_t;

	typedef struct packed {
		key_sel_t l_sel;
		key_sel_t r_sel;
	} key_mask_t;

	localparam byte_t FWD_BOX [256] = '{
		8'd205, 8'd30, 8'd131, 8'd91, 8'd49, 8'd1, 8'd147, 8'd74,
		8'd165, 8'd80, 8'd100, 8'd225, 8'd228, 8'd164, 8'd218, 8'd250,
		8'd64, 8'd93, 8'd88, 8'd213, 8'd105, 8'd18, 8'd68, 8'd208,
		8'd104, 8'd78, 8'd70, 8'd77, 8'd10, 8'd209, 8'd99, 8'd95,
		8'd234, 8'd113, 8'd11, 8'd206, 8'd203, 8'd12, 8'd47, 8'd137,
		8'd112, 8'd85, 8'd246, 8'd255, 8'd188, 8'd211, 8'd90, 8'd200,
		8'd133, 8'd63, 8'd220, 8'd242, 8'd207, 8'd53, 8'd13, 8'd116,
		8'd162, 8'd154, 8'd216, 8'd193, 8'd73, 8'd201, 8'd52, 8'd106,
		8'd79, 8'd145, 8'd23, 8'd97, 8'd28, 8'd26, 8'd163, 8'd40,
		8'd254, 8'd130, 8'd235, 8'd61, 8'd27, 8'd43, 8'd247, 8'd71,
		8'd62, 8'd172, 8'd19, 8'd33, 8'd231, 8'd150, 8'd9, 8'd66,
		8'd121, 8'd58, 8'd161, 8'd196, 8'd248, 8'd7, 8'd57, 8'd199,
		8'd253, 8'd114, 8'd59, 8'd191, 8'd8, 8'd16, 8'd22, 8'd155,
		8'd169, 8'd156, 8'd142, 8'd245, 8'd86, 8'd175, 8'd29, 8'd51,
		8'd152, 8'd202, 8'd20, 8'd42, 8'd187, 8'd108, 8'd84, 8'd118,
		8'd157, 8'd159, 8'd244, 8'd212, 8'd238, 8'd148, 8'd102, 8'd183,
		8'd197, 8'd229, 8'd126, 8'd44, 8'd5, 8'd0, 8'd189, 8'd180,
		8'd76, 8'd167, 8'd227, 8'd224, 8'd237, 8'd55, 8'd125, 8'd170,
		8'd151, 8'd103, 8'd179, 8'd136, 8'd138, 8'd222, 8'd4, 8'd110,
		8'd89, 8'd182, 8'd146, 8'd119, 8'd92, 8'd81, 8'd135, 8'd186,
		8'd50, 8'd239, 8'd153, 8'd115, 8'd82, 8'd37, 8'd190, 8'd251,
		8'd233, 8'd31, 8'd56, 8'd83, 8'd241, 8'd107, 8'd111, 8'd221,
		8'd230, 8'd192, 8'd223, 8'd65, 8'd184, 8'd219, 8'd252, 8'd72,
		8'd35, 8'd243, 8'd75, 8'd21, 8'd32, 8'd226, 8'd160, 8'd128,
		8'd198, 8'd158, 8'd123, 8'd178, 8'd117, 8'd174, 8'd41, 8'd101,
		8'd215, 8'd176, 8'd232, 8'd124, 8'd144, 8'd149, 8'd166, 8'd87,
		8'd24, 8'd17, 8'd177, 8'd25, 8'd120, 8'd240, 8'd210, 8'd132,
		8'd3, 8'd139, 8'd204, 8'd54, 8'd129, 8'd185, 8'd122, 8'd45,
		8'd39, 8'd140, 8'd171, 8'd236, 8'd134, 8'd249, 8'd15, 8'd34,
		8'd214, 8'd141, 8'd60, 8'd38, 8'd46, 8'd98, 8'd6, 8'd127,
		8'd69, 8'd14, 8'd194, 8'd36, 8'd173, 8'd143, 8'd181, 8'd48,
		8'd109, 8'd96, 8'd2, 8'd168, 8'd67, 8'd217, 8'd195, 8'd94
	};

	localparam byte_t INV_BOX [256] = '{
		8'd133, 8'd5, 8'd250, 8'd216, 8'd150, 8'd132, 8'd238, 8'd93,
		8'd100, 8'd86, 8'd28, 8'd34, 8'd37, 8'd54, 8'd241, 8'd230,
		8'd101, 8'd209, 8'd21, 8'd82, 8'd114, 8'd187, 8'd102, 8'd66,
		8'd208, 8'd211, 8'd69, 8'd76, 8'd68, 8'd110, 8'd1, 8'd169,
		8'd188, 8'd83, 8'd231, 8'd184, 8'd243, 8'd165, 8'd235, 8'd224,
		8'd71, 8'd198, 8'd115, 8'd77, 8'd131, 8'd223, 8'd236, 8'd38,
		8'd247, 8'd4, 8'd160, 8'd111, 8'd62, 8'd53, 8'd219, 8'd141,
		8'd170, 8'd94, 8'd89, 8'd98, 8'd234, 8'd75, 8'd80, 8'd49,
		8'd16, 8'd179, 8'd87, 8'd252, 8'd22, 8'd240, 8'd26, 8'd79,
		8'd183, 8'd60, 8'd7, 8'd186, 8'd136, 8'd27, 8'd25, 8'd64,
		8'd9, 8'd157, 8'd164, 8'd171, 8'd118, 8'd41, 8'd108, 8'd207,
		8'd18, 8'd152, 8'd46, 8'd3, 8'd156, 8'd17, 8'd255, 8'd31,
		8'd249, 8'd67, 8'd237, 8'd30, 8'd10, 8'd199, 8'd126, 8'd145,
		8'd24, 8'd20, 8'd63, 8'd173, 8'd117, 8'd248, 8'd151, 8'd174,
		8'd40, 8'd33, 8'd97, 8'd163, 8'd55, 8'd196, 8'd119, 8'd155,
		8'd212, 8'd88, 8'd222, 8'd194, 8'd203, 8'd142, 8'd130, 8'd239,
		8'd191, 8'd220, 8'd73, 8'd2, 8'd215, 8'd48, 8'd228, 8'd158,
		8'd147, 8'd39, 8'd148, 8'd217, 8'd225, 8'd233, 8'd106, 8'd245,
		8'd204, 8'd65, 8'd154, 8'd6, 8'd125, 8'd205, 8'd85, 8'd144,
		8'd112, 8'd162, 8'd57, 8'd103, 8'd105, 8'd120, 8'd193, 8'd121,
		8'd190, 8'd90, 8'd56, 8'd70, 8'd13, 8'd8, 8'd206, 8'd137,
		8'd251, 8'd104, 8'd143, 8'd226, 8'd81, 8'd244, 8'd197, 8'd109,
		8'd201, 8'd210, 8'd195, 8'd146, 8'd135, 8'd246, 8'd153, 8'd127,
		8'd180, 8'd221, 8'd159, 8'd116, 8'd44, 8'd134, 8'd166, 8'd99,
		8'd177, 8'd59, 8'd242, 8'd254, 8'd91, 8'd128, 8'd192, 8'd95,
		8'd47, 8'd61, 8'd113, 8'd36, 8'd218, 8'd0, 8'd35, 8'd52,
		8'd23, 8'd29, 8'd214, 8'd45, 8'd123, 8'd19, 8'd232, 8'd200,
		8'd58, 8'd253, 8'd14, 8'd181, 8'd50, 8'd175, 8'd149, 8'd178,
		8'd139, 8'd11, 8'd189, 8'd138, 8'd12, 8'd129, 8'd176, 8'd84,
		8'd202, 8'd168, 8'd32, 8'd74, 8'd227, 8'd140, 8'd124, 8'd161,
		8'd213, 8'd172, 8'd51, 8'd185, 8'd122, 8'd107, 8'd42, 8'd78,
		8'd92, 8'd229, 8'd15, 8'd167, 8'd182, 8'd96, 8'd72, 8'd43
	};

	// the round network is linear over xor: each key byte lands in l and r
	// depending on the parity of its uses and the distance to the end (period 3)
	function automatic key_mask_t build_key_mask(input logic decrypt);
		key_mask_t m;
		int idx;
		int phase;
		m = '0;
		phase = 0;
		for (int k = 0; k < ROUNDS; k++) begin
			idx = decrypt ? ((ROUNDS - (ROUNDS - 1 - k)) & (KEY_BYTES - 1))
			              : ((ROUNDS - 1 - k) & (KEY_BYTES - 1));
			if (phase == 1 || phase == 2) begin
				m.l_sel[idx] = ~m.l_sel[idx];
			end
			if (phase == 0 || phase == 1) begin
				m.r_sel[idx] = ~m.r_sel[idx];
			end
			phase = (phase == 2) ? 0 : phase + 1;
		end
		m.l_sel = m.l_sel ^ m.r_sel;
		idx = decrypt ? FINAL_IDX_DEC : FINAL_IDX_ENC;
		m.l_sel[idx] = ~m.l_sel[idx];
		return m;
	endfunction

	localparam key_mask_t KEY_MASK_ENC = build_key_mask(1'b0);
	localparam key_mask_t KEY_MASK_DEC = build_key_mask(1'b1);

	function automatic byte_t rotl8(input byte_t x, input logic [POS_W-1:0] rot);
		logic [2*BYTE_W-1:0] d;
		d = {x, x} << rot;
		return d[2*BYTE_W-1:BYTE_W];
	endfunction

endpackage

// File: design/sfc_mix.sv
// forward substitution and the collapsed feistel round network
module sfc_mix (
	input  logic                        action,
	input  logic [sfc_pkg::WORD_W-1:0]  sample_word,
	input  logic [sfc_pkg::POS_W-1:0]   sample_position,
	input  logic [sfc_pkg::KEY_W-1:0]   cipher_key,
	output sfc_pkg::byte_t              l_out,
	output sfc_pkg::byte_t              r_out
);

	sfc_pkg::byte_t    l_in;
	sfc_pkg::byte_t    r_in;
	sfc_pkg::byte_t    l_data;
	sfc_pkg::byte_t    r_data;
	sfc_pkg::byte_t    l_key;
	sfc_pkg::byte_t    r_key;
	sfc_pkg::key_mask_t mask;

	always_comb begin
		if (sfc_pkg::action_t'(action) == sfc_pkg::ACT_DECRYPT) begin
			l_in = sample_word[2*sfc_pkg::BYTE_W-1:sfc_pkg::BYTE_W];
			r_in = sample_word[sfc_pkg::BYTE_W-1:0];
			mask = sfc_pkg::KEY_MASK_DEC;
		end else begin
			l_in = sfc_pkg::FWD_BOX[sample_word[2*sfc_pkg::BYTE_W-1:sfc_pkg::BYTE_W]];
			r_in = sfc_pkg::FWD_BOX[sample_word[sfc_pkg::BYTE_W-1:0]];
			mask = sfc_pkg::KEY_MASK_ENC;
		end
	end

	always_comb begin
		case (sfc_pkg::ROUNDS_MOD3)
			1: begin
				l_data = l_in;
				r_data = l_in ^ r_in;
			end
			2: begin
				l_data = r_in;
				r_data = l_in;
			end
			default: begin
				l_data = l_in ^ r_in;
				r_data = r_in;
			end
		endcase
	end

	// key bytes, most significant first
	always_comb begin
		l_key = '0;
		r_key = '0;
		for (int b = 0; b < sfc_pkg::KEY_BYTES; b++) begin
			if (mask.l_sel[b]) begin
				l_key = l_key ^ cipher_key[sfc_pkg::KEY_W-1-sfc_pkg::BYTE_W*b -: sfc_pkg::BYTE_W];
			end
			if (mask.r_sel[b]) begin
				r_key = r_key ^ cipher_key[sfc_pkg::KEY_W-1-sfc_pkg::BYTE_W*b -: sfc_pkg::BYTE_W];
			end
		end
	end

	assign l_out = l_data ^ sfc_pkg::rotl8(l_key, sample_position);
	assign r_out = r_data ^ sfc_pkg::rotl8(r_key, sample_position);

endmodule

// File: design/sfc_unsub.sv
// inverse substitution on the decrypt path and word assembly
module sfc_unsub (
	input  logic                        action,
	input  sfc_pkg::byte_t              l_in,
	input  sfc_pkg::byte_t              r_in,
	output logic [sfc_pkg::WORD_W-1:0]  word_out
);

	always_comb begin
		if (sfc_pkg::action_t'(action) == sfc_pkg::ACT_DECRYPT) begin
			word_out = {sfc_pkg::INV_BOX[l_in], sfc_pkg::INV_BOX[r_in]};
		end else begin
			word_out = {l_in, r_in};
		end
	end

endmodule

// File: design/sbox_feistel_cipher_16bit.sv
// top level of the 16-bit s-box feistel cipher for audio words
// Enciphers (action 0) or deciphers (action 1) one 16-bit word per transaction under
// the 64-bit key written on the cfg channel (reset value 0; write only while idle).
// One transaction is accepted every clock cycle while in_stall is low (out_stall can stall
// the pipeline); a result moves from the input register through the substitution/round
// stage register to the output register. cfg_ready is always high.
module sbox_feistel_cipher_16bit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sfc_pkg::KEY_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic [sfc_pkg::WORD_W-1:0]  sample_word,
	input  logic [sfc_pkg::POS_W-1:0]   sample_position,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [sfc_pkg::WORD_W-1:0]  result_word
);

	logic [sfc_pkg::KEY_W-1:0]  key_q;
	logic                       v_s1;
	logic                       action_s1;
	logic [sfc_pkg::WORD_W-1:0] word_s1;
	logic [sfc_pkg::POS_W-1:0]  pos_s1;
	logic                       v_s2;
	logic                       action_s2;
	sfc_pkg::byte_t             l_s2;
	sfc_pkg::byte_t             r_s2;
	logic                       out_valid_q;
	logic [sfc_pkg::WORD_W-1:0] result_q;
	sfc_pkg::byte_t             l_mix;
	sfc_pkg::byte_t             r_mix;
	logic [sfc_pkg::WORD_W-1:0] word_fin;
	logic                       adv_out;
	logic                       ld_s2;
	logic                       ld_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			key_q <= cfg_data;
		end
	end

	assign adv_out  = !out_valid_q || !out_stall;
	assign ld_s2    = !v_s2 || adv_out;
	assign ld_s1    = !v_s1 || ld_s2;
	assign in_stall = !ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1) begin
				v_s1 <= in_valid;
			end
			if (ld_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && in_valid) begin
			action_s1 <= action;
			word_s1   <= sample_word;
			pos_s1    <= sample_position;
		end
		if (ld_s2 && v_s1) begin
			action_s2 <= action_s1;
			l_s2      <= l_mix;
			r_s2      <= r_mix;
		end
		if (adv_out && v_s2) begin
			result_q <= word_fin;
		end
	end

	sfc_mix u_mix (
		.action          (action_s1),
		.sample_word     (word_s1),
		.sample_position (pos_s1),
		.cipher_key      (key_q),
		.l_out           (l_mix),
		.r_out           (r_mix)
	);

	sfc_unsub u_unsub (
		.action   (action_s2),
		.l_in     (l_s2),
		.r_in     (r_s2),
		.word_out (word_fin)
	);

	assign out_valid   = out_valid_q;
	assign result_word = result_q;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && out_valid_q))
		else $error("input stalled with room in the pipeline");

	a_blocked_pipe_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && out_valid_q && out_stall) |-> in_stall)
		else $error("full blocked pipeline did not stall input");

	a_out_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !out_valid_q) |=> out_valid_q)
		else $error("stage 2 transaction not moved to output");

	a_s2_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !v_s2) |=> v_s2)
		else $error("stage 1 transaction not moved to stage 2");
`endif

endmodule

// File: sim/sbox_feistel_cipher_16bit_tb.sv
// testbench for the 16-bit s-box feistel cipher: directed and random words checked against a predictor
module sbox_feistel_cipher_16bit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_PHASES = 8;
	localparam int WORDS_PER_PHASE = 200;
	localparam int DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [sfc_pkg::KEY_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = sfc_pkg::ACT_ENCRYPT;
	logic [sfc_pkg::WORD_W-1:0] sample_word = '0;
	logic [sfc_pkg::POS_W-1:0] sample_position = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [sfc_pkg::WORD_W-1:0] result_word;

	logic [sfc_pkg::KEY_W-1:0] key_q = '0;
	logic [sfc_pkg::WORD_W-1:0] expected_words[$];
	int error_count = 0;
	int cycle_count = 0;
	bit in_gaps_on = 1'b0;
	bit out_stalls_on = 1'b0;

	sbox_feistel_cipher_16bit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.sample_word(sample_word),
		.sample_position(sample_position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_word(result_word)
	);

	always #2 clk = ~clk;

	// round key: key byte sel (0 = most significant) rotated left by pos
	function automatic sfc_pkg::byte_t round_key_byte(input logic [2:0] sel,
			input logic [sfc_pkg::POS_W-1:0] pos);
		sfc_pkg::byte_t b;
		b = key_q[(7 - sel) * sfc_pkg::BYTE_W +: sfc_pkg::BYTE_W];
		for (int i = 0; i < pos; i++) begin
			b = {b[sfc_pkg::BYTE_W-2:0], b[sfc_pkg::BYTE_W-1]};
		end
		return b;
	endfunction

	function automatic logic [sfc_pkg::WORD_W-1:0] cipher_word(input sfc_pkg::action_t act,
			input logic [sfc_pkg::WORD_W-1:0] w, input logic [sfc_pkg::POS_W-1:0] pos);
		sfc_pkg::byte_t lh;
		sfc_pkg::byte_t rh;
		sfc_pkg::byte_t t;
		logic [2:0] sel;
		if (act == sfc_pkg::ACT_ENCRYPT) begin
			lh = sfc_pkg::FWD_BOX[w[15:8]];
			rh = sfc_pkg::FWD_BOX[w[7:0]];
		end else begin
			lh = w[15:8];
			rh = w[7:0];
		end
		for (int k = 0; k < sfc_pkg::ROUNDS; k++) begin
			sel = (act == sfc_pkg::ACT_DECRYPT) ? 3'(sfc_pkg::ROUNDS - k) : 3'(k);
			t = lh ^ rh ^ round_key_byte(sel, pos);
			lh = rh;
			rh = t;
		end
		sel = (act == sfc_pkg::ACT_DECRYPT) ? 3'd0 : 3'(sfc_pkg::ROUNDS);
		lh = lh ^ rh ^ round_key_byte(sel, pos);
		if (act == sfc_pkg::ACT_DECRYPT) begin
			lh = sfc_pkg::INV_BOX[lh];
			rh = sfc_pkg::INV_BOX[rh];
		end
		return {lh, rh};
	endfunction

	// mostly short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [sfc_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 16'(1) << $urandom_range(0, sfc_pkg::WORD_W - 1);
			3: return ~(16'(1) << $urandom_range(0, sfc_pkg::WORD_W - 1));
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [sfc_pkg::WORD_W-1:0] exp_w,
			input logic [sfc_pkg::WORD_W-1:0] got_w);
		$display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, exp_w, got_w);
		error_count++;
	endtask

	task automatic write_key(input logic [sfc_pkg::KEY_W-1:0] k);
		cfg_valid <= 1'b1;
		cfg_data <= k;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		key_q = k;
	endtask

	task automatic send_word(input sfc_pkg::action_t act, input logic [sfc_pkg::WORD_W-1:0] w,
			input logic [sfc_pkg::POS_W-1:0] pos, input int gap,
			output logic [sfc_pkg::WORD_W-1:0] predicted);
		in_valid <= 1'b1;
		action <= act;
		sample_word <= w;
		sample_position <= pos;
		do @(posedge clk); while (in_stall);
		predicted = cipher_word(act, w, pos);
		expected_words.push_back(predicted);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic int in_gap();
		return in_gaps_on ? gap_len() : 0;
	endfunction

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	// key still at its reset value
	task automatic test_reset_key();
		logic [sfc_pkg::WORD_W-1:0] res;
		send_word(sfc_pkg::ACT_ENCRYPT, 16'h0000, 3'd0, in_gap(), res);
		send_word(sfc_pkg::ACT_DECRYPT, 16'hFFFF, 3'd7, in_gap(), res);
		send_word(sfc_pkg::ACT_ENCRYPT, 16'hFFFF, 3'd3, in_gap(), res);
		send_word(sfc_pkg::ACT_DECRYPT, 16'h0000, 3'd0, in_gap(), res);
		wait_idle();
	endtask

	task automatic test_key_extremes();
		logic [sfc_pkg::WORD_W-1:0] res;
		write_key('1);
		send_word(sfc_pkg::ACT_ENCRYPT, 16'h8001, 3'd5, in_gap(), res);
		send_word(sfc_pkg::ACT_DECRYPT, 16'h7FFE, 3'd0, in_gap(), res);
		wait_idle();
	endtask

	task automatic test_position_sweep();
		logic [sfc_pkg::WORD_W-1:0] res;
		write_key(64'h0123456789ABCDEF);
		for (int p = 0; p < 8; p++) begin
			send_word(sfc_pkg::action_t'(p[0]), 16'hA5C3, 3'(p), in_gap(), res);
		end
		wait_idle();
	endtask

	task automatic test_round_trip();
		logic [sfc_pkg::WORD_W-1:0] ct;
		logic [sfc_pkg::WORD_W-1:0] pt;
		write_key(64'h8000000000000001);
		send_word(sfc_pkg::ACT_ENCRYPT, 16'h1234, 3'd1, in_gap(), ct);
		send_word(sfc_pkg::ACT_DECRYPT, ct, 3'd1, in_gap(), pt);
		send_word(sfc_pkg::ACT_ENCRYPT, 16'hFF00, 3'd6, in_gap(), ct);
		send_word(sfc_pkg::ACT_DECRYPT, ct, 3'd6, in_gap(), pt);
		wait_idle();
	endtask

	task automatic test_random_stream();
		logic [sfc_pkg::WORD_W-1:0] res;
		logic [sfc_pkg::WORD_W-1:0] prev_ct;
		logic [sfc_pkg::POS_W-1:0] prev_pos;
		logic [sfc_pkg::POS_W-1:0] pos;
		logic [sfc_pkg::KEY_W-1:0] k;
		bit have_ct;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			case (ph)
				1: k = '0;
				2: k = '1;
				3: k = 64'(1) << $urandom_range(0, sfc_pkg::KEY_W - 1);
				default: k = {$urandom(), $urandom()};
			endcase
			write_key(k);
			in_gaps_on = (ph != 0) && (ph != 2);
			out_stalls_on = (ph != 0) && (ph != 1);
			have_ct = 1'b0;
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if (have_ct && $urandom_range(0, 3) == 0) begin
					send_word(sfc_pkg::ACT_DECRYPT, prev_ct, prev_pos, in_gap(), res);
					have_ct = 1'b0;
				end else begin
					pos = 3'($urandom_range(0, 7));
					if ($urandom_range(0, 1) == 0) begin
						send_word(sfc_pkg::ACT_ENCRYPT, pick_word(), pos, in_gap(), res);
						prev_ct = res;
						prev_pos = pos;
						have_ct = 1'b1;
					end else begin
						send_word(sfc_pkg::ACT_DECRYPT, pick_word(), pos, in_gap(), res);
					end
				end
			end
		end
		wait_idle();
	endtask

	// output side back-pressure
	int stall_hold = 0;
	bit stall_next;
	always @(posedge clk) begin
		if (!out_stalls_on) begin
			out_stall <= 1'b0;
			stall_hold = 0;
		end else if (stall_hold == 0) begin
			stall_next = ($urandom_range(0, 2) == 0);
			stall_hold = stall_next ? gap_len() + 1 : $urandom_range(1, 8);
			out_stall <= stall_next;
		end else begin
			stall_hold--;
		end
	end

	// result checker
	logic [sfc_pkg::WORD_W-1:0] exp_word;
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected result_word", '0, result_word);
			end else begin
				exp_word = expected_words.pop_front();
				if (result_word !== exp_word) begin
					report_mismatch("result_word", exp_word, result_word);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_key();
		in_gaps_on = 1'b1;
		out_stalls_on = 1'b1;
		test_key_extremes();
		test_position_sweep();
		test_round_trip();
		test_random_stream();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_words.size() != 0) begin
			report_mismatch("missing transactions, count", 16'(expected_words.size()), '0);
		end
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: sim.f
design/sfc_pkg.sv
design/sfc_mix.sv
design/sfc_unsub.sv
design/sbox_feistel_cipher_16bit.sv
sim/sbox_feistel_cipher_16bit_tb.sv
